/* sv/pmfb_pkg.sv */
// shared types and constants for the paged monochrome framebuffer
// no dependencies; used by pmfb_ctrl and paged_mono_framebuffer_fill
package pmfb_pkg;

    // store geometry defaults
    localparam int MAX_WIDTH_DEF = 128;
    localparam int MAX_PAGES_DEF = 8;

    // fixed field widths
    localparam int COORD_W    = 8;
    localparam int PAGE_W     = 5;
    localparam int ROW_W      = 3;
    localparam int SPAN_W     = COORD_W + 1;
    localparam int PROD_W     = PAGE_W + COORD_W;
    localparam int DWIDTH_W   = 8;
    localparam int DHEIGHT_W  = 7;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int BYTE_W     = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HEIGHT = 1'b1;

    // register reset values
    localparam logic [DWIDTH_W-1:0]  DWIDTH_RST  = 8'd128;
    localparam logic [DHEIGHT_W-1:0] DHEIGHT_RST = 7'd64;

    // operation codes
    localparam logic OP_FILL = 1'b0;
    localparam logic OP_READ = 1'b1;

    // byte mask and last row index
    localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
    localparam logic [ROW_W-1:0]  ROW_LAST  = 3'd7;

    typedef struct packed {
        logic               operation;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic               colour;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic pixel_value;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_RWAIT,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

/* sv/pmfb_ram.sv */
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
module pmfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/pmfb_ctrl.sv */
// command sequencer: clearing pass, rectangle walk with read-modify-write, pixel read
// depends on pmfb_pkg and pmfb_ram
module pmfb_ctrl #(
    parameter int MAX_WIDTH = pmfb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_PAGES = pmfb_pkg::MAX_PAGES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  pmfb_pkg::t_cmd                   i_cmd,
    input  logic [pmfb_pkg::COORD_W-1:0]     i_act_w,
    input  logic [pmfb_pkg::DHEIGHT_W-1:0]   i_act_h,
    input  logic                             i_res_ready,
    output logic                             o_ready,
    output pmfb_pkg::t_result                o_res
);

    localparam int DEPTH  = MAX_WIDTH * MAX_PAGES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    localparam int CW = pmfb_pkg::COORD_W;
    localparam int SW = pmfb_pkg::SPAN_W;
    localparam int PW = pmfb_pkg::PAGE_W;
    localparam int RW = pmfb_pkg::ROW_W;
    localparam int BW = pmfb_pkg::BYTE_W;
    localparam int MW = pmfb_pkg::PROD_W;

    pmfb_pkg::t_state r_state, n_state;
    pmfb_pkg::t_cmd   r_cmd, n_cmd;
    logic [CW-1:0]     r_x, n_x;
    logic [PW-1:0]     r_page, n_page;
    logic [PW-1:0]     r_fp, n_fp;
    logic [PW-1:0]     r_lp, n_lp;
    logic [RW-1:0]     r_lo, n_lo;
    logic [RW-1:0]     r_hi, n_hi;
    logic [SW-1:0]     r_xe, n_xe;
    logic [MW-1:0]     r_base, n_base;
    logic              r_pix, n_pix;
    logic              r_wv, n_wv;
    logic [ADDR_W-1:0] r_wa, n_wa;
    logic [BW-1:0]     r_wm, n_wm;
    logic [ADDR_W-1:0] r_clr, n_clr;

    // memory port signals
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [BW-1:0]     mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [BW-1:0]     mem_rdata;

    // clipping and setup values
    logic [SW-1:0] x_sum, x_end, y_sum, y_end, y_last;
    logic          fill_empty, read_in;
    logic [MW-1:0] base_prod;

    // walk values
    logic [ADDR_W-1:0] walk_addr;
    logic [RW-1:0]     lo_bit, hi_bit;
    logic [BW-1:0]     walk_mask;
    logic              last_col;

    pmfb_ram #(
        .WIDTH(BW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // clip the rectangle to the active area
    always_comb begin
        x_sum      = SW'(r_cmd.x_start) + SW'(r_cmd.rect_width);
        x_end      = (x_sum > SW'(i_act_w)) ? SW'(i_act_w) : x_sum;
        y_sum      = SW'(r_cmd.y_start) + SW'(r_cmd.rect_height);
        y_end      = (y_sum > SW'(i_act_h)) ? SW'(i_act_h) : y_sum;
        y_last     = y_end - SW'(1);
        fill_empty = (SW'(r_cmd.x_start) >= x_end) || (SW'(r_cmd.y_start) >= y_end);
        read_in    = (r_cmd.x_start < i_act_w) && (r_cmd.y_start < CW'(i_act_h));
        base_prod  = MW'(r_cmd.y_start[CW-1:RW]) * MW'(i_act_w);
    end

    // byte address and row mask of the current walk position
    always_comb begin
        walk_addr = ADDR_W'(r_base + MW'(r_x));
        lo_bit    = (r_page == r_fp) ? r_lo : '0;
        hi_bit    = (r_page == r_lp) ? r_hi : pmfb_pkg::ROW_LAST;
        walk_mask = (pmfb_pkg::BYTE_ONES << lo_bit)
                  & (pmfb_pkg::BYTE_ONES >> (pmfb_pkg::ROW_LAST - hi_bit));
        last_col  = (SW'(r_x) + SW'(1)) == r_xe;
    end

    // next state and memory control
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_x     = r_x;
        n_page  = r_page;
        n_fp    = r_fp;
        n_lp    = r_lp;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_xe    = r_xe;
        n_base  = r_base;
        n_pix   = r_pix;
        n_wv    = 1'b0;
        n_wa    = r_wa;
        n_wm    = r_wm;
        n_clr   = r_clr;

        mem_re    = 1'b0;
        mem_raddr = walk_addr;
        o_ready   = 1'b0;
        o_res     = '{valid: 1'b0, pixel_value: r_pix};

        // write-back of the byte read in the previous cycle, or the clearing pass
        if (r_state == pmfb_pkg::ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else begin
            mem_we    = r_wv;
            mem_waddr = r_wa;
            mem_wdata = r_cmd.colour ? (mem_rdata | r_wm) : (mem_rdata & ~r_wm);
        end

        unique case (r_state)
            pmfb_pkg::ST_CLEAR: begin
                if (r_clr == LAST_ADDR) begin
                    n_state = pmfb_pkg::ST_IDLE;
                end else begin
                    n_clr = r_clr + ADDR_W'(1);
                end
            end
            pmfb_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_state = pmfb_pkg::ST_SETUP;
                end
            end
            pmfb_pkg::ST_SETUP: begin
                n_base = base_prod;
                n_x    = r_cmd.x_start;
                n_page = r_cmd.y_start[CW-1:RW];
                n_fp   = r_cmd.y_start[CW-1:RW];
                n_lp   = y_last[CW-1:RW];
                n_lo   = r_cmd.y_start[RW-1:0];
                n_hi   = y_last[RW-1:0];
                n_xe   = x_end;
                n_pix  = 1'b0;
                if (r_cmd.operation == pmfb_pkg::OP_READ) begin
                    n_state = read_in ? pmfb_pkg::ST_READ : pmfb_pkg::ST_DONE;
                end else begin
                    n_state = fill_empty ? pmfb_pkg::ST_DONE : pmfb_pkg::ST_WALK;
                end
            end
            pmfb_pkg::ST_READ: begin
                mem_re  = 1'b1;
                n_state = pmfb_pkg::ST_RWAIT;
            end
            pmfb_pkg::ST_RWAIT: begin
                n_pix   = mem_rdata[r_cmd.y_start[RW-1:0]];
                n_state = pmfb_pkg::ST_DONE;
            end
            pmfb_pkg::ST_WALK: begin
                // read this byte now, write it back next cycle
                mem_re = 1'b1;
                n_wv   = 1'b1;
                n_wa   = walk_addr;
                n_wm   = walk_mask;
                if (last_col) begin
                    if (r_page == r_lp) begin
                        n_state = pmfb_pkg::ST_DRAIN;
                    end else begin
                        n_page = r_page + PW'(1);
                        n_x    = r_cmd.x_start;
                        n_base = r_base + MW'(i_act_w);
                    end
                end else begin
                    n_x = r_x + CW'(1);
                end
            end
            pmfb_pkg::ST_DRAIN: begin
                n_state = pmfb_pkg::ST_DONE;
            end
            pmfb_pkg::ST_DONE: begin
                o_res.valid = 1'b1;
                if (i_res_ready) begin
                    n_state = pmfb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pmfb_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmfb_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_wv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_wv    <= n_wv;
        end
    end

    // command and walk registers
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_x    <= n_x;
        r_page <= n_page;
        r_fp   <= n_fp;
        r_lp   <= n_lp;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_xe   <= n_xe;
        r_base <= n_base;
        r_pix  <= n_pix;
        r_wa   <= n_wa;
        r_wm   <= n_wm;
    end

endmodule

/* sv/paged_mono_framebuffer_fill.sv */
// top level of the paged monochrome framebuffer: registers, request ports, result register
// depends on pmfb_pkg and pmfb_ctrl
//
// One bit per pixel, stored in pages of eight rows: pixel (x,y) is bit y%8 of byte
// (y/8)*W+x, W being the active width. A fill request sets or clears a clipped rectangle,
// walking it page by page and column by column with one read-modify-write per byte; a
// read request returns one pixel, or 0 outside the active area. After reset a clearing
// pass writes zero to all MAX_WIDTH*MAX_PAGES bytes, one per cycle, before the first
// request is taken. One request is handled at a time: the input stays stalled while a fill
// passes setup, walk, drain and result, or a read passes setup, read, wait and result
// (empty fills and reads outside the area go from setup to result), as the single memory
// read port gives one byte per cycle and each write-back follows its read in the next
// cycle. A result waits in the output register while the next request is already taken.
module paged_mono_framebuffer_fill #(
    parameter int MAX_WIDTH = pmfb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_PAGES = pmfb_pkg::MAX_PAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic [pmfb_pkg::COORD_W-1:0]      i_x_start,
    input  logic [pmfb_pkg::COORD_W-1:0]      i_y_start,
    input  logic [pmfb_pkg::COORD_W-1:0]      i_rect_width,
    input  logic [pmfb_pkg::COORD_W-1:0]      i_rect_height,
    input  logic                              i_colour,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_pixel_value,
    // register write port
    input  logic                              i_cfg_we,
    input  logic [pmfb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pmfb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic [pmfb_pkg::SPAN_W-1:0] WIDTH_LIM  = pmfb_pkg::SPAN_W'(MAX_WIDTH);
    localparam logic [pmfb_pkg::COORD_W-1:0] HEIGHT_LIM = pmfb_pkg::COORD_W'(MAX_PAGES * 8);

    logic [pmfb_pkg::DWIDTH_W-1:0]  r_disp_w;
    logic [pmfb_pkg::DHEIGHT_W-1:0] r_disp_h;
    logic [pmfb_pkg::COORD_W-1:0]   act_w;
    logic [pmfb_pkg::DHEIGHT_W-1:0] act_h;

    logic              ctrl_ready;
    logic              req_accept;
    logic              res_ready;
    pmfb_pkg::t_cmd    req_cmd;
    pmfb_pkg::t_result ctrl_res;

    logic r_out_valid;
    logic r_pixel;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_w <= pmfb_pkg::DWIDTH_RST;
            r_disp_h <= pmfb_pkg::DHEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pmfb_pkg::CFG_DISPLAY_WIDTH:  r_disp_w <= i_cfg_data;
                pmfb_pkg::CFG_DISPLAY_HEIGHT: r_disp_h <= i_cfg_data[pmfb_pkg::DHEIGHT_W-1:0];
            endcase
        end
    end

    // active area limited to the store
    always_comb begin
        act_w = (pmfb_pkg::SPAN_W'(r_disp_w) > WIDTH_LIM)
              ? WIDTH_LIM[pmfb_pkg::COORD_W-1:0] : r_disp_w;
        act_h = (pmfb_pkg::COORD_W'(r_disp_h) > HEIGHT_LIM)
              ? HEIGHT_LIM[pmfb_pkg::DHEIGHT_W-1:0] : r_disp_h;
    end

    // request handshake
    assign o_in_stall = !ctrl_ready;
    assign req_accept = i_in_valid && ctrl_ready;
    assign req_cmd    = '{operation:   i_operation,
                          x_start:     i_x_start,
                          y_start:     i_y_start,
                          rect_width:  i_rect_width,
                          rect_height: i_rect_height,
                          colour:      i_colour};

    pmfb_ctrl #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_PAGES(MAX_PAGES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (req_accept),
        .i_cmd      (req_cmd),
        .i_act_w    (act_w),
        .i_act_h    (act_h),
        .i_res_ready(res_ready),
        .o_ready    (ctrl_ready),
        .o_res      (ctrl_res)
    );

    // output register
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_res.valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl_res.valid && res_ready) begin
            r_pixel <= ctrl_res.pixel_value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_value = r_pixel;

endmodule

/* sim/tb_top.sv */
// self-checking testbench for paged_mono_framebuffer_fill: directed and random fill/read requests
// keeps its own copy of the page-layout frame store to predict each read; depends on pmfb_pkg
`timescale 1ns / 1ps

module tb_top;
    import pmfb_pkg::*;

    localparam int STORE_BYTES  = MAX_WIDTH_DEF * MAX_PAGES_DEF;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 72;
    localparam int HOLD_PHASE   = 4;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE_TICKS = 16;
    localparam int CYCLE_LIMIT  = 3000000;

    // predicts the pixel returned by each request and checks results in order
    class pixel_scoreboard;
        logic [BYTE_W-1:0]    shadow_frame [STORE_BYTES];
        logic [DWIDTH_W-1:0]  width_reg;
        logic [DHEIGHT_W-1:0] height_reg;
        bit                   pending_pixels [$];
        int                   results_seen;
        int                   errors;

        function new();
            foreach (shadow_frame[i]) shadow_frame[i] = '0;
            width_reg    = DWIDTH_RST;
            height_reg   = DHEIGHT_RST;
            results_seen = 0;
            errors       = 0;
        endfunction

        function int active_width();
            return (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
        endfunction

        function int active_height();
            return (height_reg > MAX_PAGES_DEF * 8) ? MAX_PAGES_DEF * 8 : int'(height_reg);
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] reg_index,
                                   input logic [CFG_DATA_W-1:0] data);
            case (reg_index)
                CFG_DISPLAY_WIDTH:  width_reg  = data[DWIDTH_W-1:0];
                CFG_DISPLAY_HEIGHT: height_reg = data[DHEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        // apply one accepted request to the shadow store and queue its pixel
        function void note_request(input t_cmd c);
            int w, h, x0, y0, x_end, y_end, x, y, addr;
            bit pixel;
            w     = active_width();
            h     = active_height();
            x0    = int'(c.x_start);
            y0    = int'(c.y_start);
            x_end = x0 + int'(c.rect_width);
            y_end = y0 + int'(c.rect_height);
            pixel = 1'b0;
            if (c.operation == OP_READ) begin
                if (x0 < w && y0 < h) begin
                    addr = (y0 >> 3) * w + x0;
                    if (addr < STORE_BYTES) pixel = shadow_frame[addr][y0[2:0]];
                end
            end else begin
                // clipped rectangle, one bit per pixel
                for (x = x0; x < x_end && x < w; x++) begin
                    for (y = y0; y < y_end && y < h; y++) begin
                        addr = (y >> 3) * w + x;
                        if (addr < STORE_BYTES) shadow_frame[addr][y[2:0]] = c.colour;
                    end
                end
            end
            pending_pixels.push_back(pixel);
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_pixel(input logic got);
            bit want;
            results_seen++;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no request pending",
                                          results_seen));
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("result %0d pixel_value %b, expected %b",
                                              results_seen, got, want));
            end
        endtask
    endclass

    // block ports
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic                  i_operation   = OP_FILL;
    logic [COORD_W-1:0]    i_x_start     = '0;
    logic [COORD_W-1:0]    i_y_start     = '0;
    logic [COORD_W-1:0]    i_rect_width  = '0;
    logic [COORD_W-1:0]    i_rect_height = '0;
    logic                  i_colour      = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic                  o_pixel_value;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_DISPLAY_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    pixel_scoreboard sb;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    bit              hold_req       = 1'b0;
    bit              hold_used      = 1'b0;
    int              hold_left      = 0;
    int              cycle_count    = 0;
    logic [7:0]      phase_width  [N_PHASES];
    logic [7:0]      phase_height [N_PHASES];

    paged_mono_framebuffer_fill i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_colour      (i_colour),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_value (o_pixel_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: check accepted results, then pick next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_pixel(o_pixel_value);
        if (hold_req && !hold_used) begin
            hold_left = LONG_HOLD;
            hold_used = 1'b1;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic t_cmd make_cmd(input logic op, input int x, input int y,
                                      input int rw, input int rh, input logic colour);
        t_cmd c;
        c.operation   = op;
        c.x_start     = x[7:0];
        c.y_start     = y[7:0];
        c.rect_width  = rw[7:0];
        c.rect_height = rh[7:0];
        c.colour      = colour;
        return c;
    endfunction

    // offer one request, with random idle cycles first, and wait for acceptance
    task automatic send_request(input t_cmd c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= c.operation;
        i_x_start     <= c.x_start;
        i_y_start     <= c.y_start;
        i_rect_width  <= c.rect_width;
        i_rect_height <= c.rect_height;
        i_colour      <= c.colour;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(c);
    endtask

    // stop offering, let every result come back and the last write-back finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_display_size(input logic [7:0] w, input logic [7:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DISPLAY_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        sb.set_register(CFG_DISPLAY_WIDTH, w);
        i_cfg_index <= CFG_DISPLAY_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        sb.set_register(CFG_DISPLAY_HEIGHT, h);
        i_cfg_we    <= 1'b0;
    endtask

    // edges, lines, clipping and empty fills at 128x64
    task automatic run_directed();
        send_request(make_cmd(OP_READ, 0, 0, 0, 0, 1'b0));
        send_request(make_cmd(OP_READ, 127, 63, 255, 255, 1'b1));
        send_request(make_cmd(OP_FILL, 0, 0, 255, 255, 1'b1));
        send_request(make_cmd(OP_READ, 127, 63, 0, 0, 1'b0));
        send_request(make_cmd(OP_READ, 0, 0, 0, 0, 1'b0));
        send_request(make_cmd(OP_READ, 128, 0, 0, 0, 1'b0));
        send_request(make_cmd(OP_READ, 0, 64, 0, 0, 1'b0));
        send_request(make_cmd(OP_READ, 255, 255, 255, 255, 1'b1));
        send_request(make_cmd(OP_FILL, 0, 0, 255, 255, 1'b0));
        // single pixel
        send_request(make_cmd(OP_FILL, 5, 9, 1, 1, 1'b1));
        send_request(make_cmd(OP_READ, 5, 9, 0, 0, 1'b0));
        send_request(make_cmd(OP_READ, 5, 8, 0, 0, 1'b0));
        // vertical line across pages
        send_request(make_cmd(OP_FILL, 20, 3, 1, 20, 1'b1));
        send_request(make_cmd(OP_READ, 20, 22, 0, 0, 1'b0));
        send_request(make_cmd(OP_READ, 20, 23, 0, 0, 1'b0));
        // horizontal line clipped at the right edge, then partly cleared
        send_request(make_cmd(OP_FILL, 100, 40, 255, 1, 1'b1));
        send_request(make_cmd(OP_READ, 127, 40, 0, 0, 1'b0));
        send_request(make_cmd(OP_FILL, 110, 40, 5, 1, 1'b0));
        send_request(make_cmd(OP_READ, 112, 40, 0, 0, 1'b0));
        send_request(make_cmd(OP_READ, 115, 40, 0, 0, 1'b0));
        // empty fills and a fill wholly off the area
        send_request(make_cmd(OP_FILL, 50, 50, 0, 10, 1'b1));
        send_request(make_cmd(OP_FILL, 50, 50, 10, 0, 1'b1));
        send_request(make_cmd(OP_FILL, 200, 10, 20, 20, 1'b1));
        send_request(make_cmd(OP_READ, 50, 50, 0, 0, 1'b0));
        // bottom right corner, clipped both ways
        send_request(make_cmd(OP_FILL, 120, 60, 255, 255, 1'b1));
        send_request(make_cmd(OP_READ, 127, 63, 0, 0, 1'b0));
    endtask

    // mostly draw-then-probe groups, plus loose reads and fully random requests
    task automatic run_random_phase(input int n_items);
        int   sent, xr, yr, kind, roll, rw, rh, px, py;
        t_cmd c;
        sent = 0;
        while (sent < n_items) begin
            xr   = sb.active_width() + 4;
            yr   = sb.active_height() + 4;
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    rw = $urandom_range(0, 255);
                    rh = $urandom_range(0, 255);
                end else if (roll < 20) begin
                    rw = $urandom_range(1, 40);
                    rh = 1;
                end else if (roll < 32) begin
                    rw = 1;
                    rh = $urandom_range(1, 30);
                end else begin
                    rw = $urandom_range(0, 10);
                    rh = $urandom_range(0, 18);
                end
                c = make_cmd(OP_FILL, $urandom_range(0, xr - 1), $urandom_range(0, yr - 1),
                             rw, rh, 1'($urandom_range(0, 1)));
                send_request(c);
                sent++;
                // probe in and just around the rectangle
                repeat ($urandom_range(1, 4)) begin
                    px = int'(c.x_start) + $urandom_range(0, rw + 1) - 1;
                    py = int'(c.y_start) + $urandom_range(0, rh + 1) - 1;
                    send_request(make_cmd(OP_READ, px, py, $urandom_range(0, 255),
                                          $urandom_range(0, 255), 1'($urandom_range(0, 1))));
                    sent++;
                end
            end else if (kind < 85) begin
                send_request(make_cmd(OP_READ, $urandom_range(0, xr - 1),
                                      $urandom_range(0, yr - 1), $urandom_range(0, 255),
                                      $urandom_range(0, 255), 1'($urandom_range(0, 1))));
                sent++;
            end else begin
                send_request(make_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                                      $urandom_range(0, 255), $urandom_range(0, 255),
                                      $urandom_range(0, 255), 1'($urandom_range(0, 1))));
                sent++;
            end
        end
    endtask

    // main sequence
    initial begin
        int p;
        sb = new();
        phase_width  = '{8'd128, 8'hFF, 8'd100, 8'd1, 8'd13, 8'd0, 8'd64, 8'd128};
        phase_height = '{8'd64, 8'hFF, 8'd40, 8'd1, 8'd57, 8'd37, 8'd0, 8'd64};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // clearing pass after reset holds the input stalled
        while (o_in_stall) @(posedge i_clk);

        write_display_size(8'd128, 8'd64);
        run_directed();

        for (p = 0; p < N_PHASES; p++) begin
            settle();
            write_display_size(phase_width[p], phase_height[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            // long result hold-off while requests keep coming
            if (p == HOLD_PHASE) hold_req = 1'b1;
            run_random_phase(PHASE_ITEMS);
        end

        settle();
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
